[sv/ps2s1_pkg.sv]
`default_nettype none

package ps2s1_pkg;

    // Scan code set 1 framing
    localparam int unsigned MAKE_CODE_RANGE = 128;
    localparam logic [7:0]  PREFIX_BYTE     = 8'hE0;
    localparam logic [6:0]  LSHIFT_MAKE     = 7'h2A;
    localparam logic [6:0]  RSHIFT_MAKE     = 7'h36;

    // Size of the per-key down store
    localparam int unsigned KEY_CODE_SPACE_DEF = 256;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W    = 1;
    localparam int unsigned CFG_DATA_W     = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_SHIFT  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_SHIFT = 1'd1;
    localparam logic [7:0] LEFT_SHIFT_RESET  = 8'd128;
    localparam logic [7:0] RIGHT_SHIFT_RESET = 8'd129;

    // Event kinds
    localparam logic [1:0] KIND_DOWN = 2'd0;
    localparam logic [1:0] KIND_UP   = 2'd1;
    localparam logic [1:0] KIND_CHAR = 2'd2;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] key_value;
        logic       was_down;
        logic       last_of_run;
    } event_t;

    // Decode of one byte: results, next prefix state and key store update
    typedef struct packed {
        logic [1:0] count;
        event_t     ev0;
        event_t     ev1;
        logic       prefix_next;
        logic       upd_en;
        logic       upd_val;
        logic [7:0] upd_code;
    } dec_t;

    // Fixed make-code map: digits and letters, zero when unmapped
    function automatic logic [7:0] make_rom(input logic [6:0] sc);
        logic [7:0] r;
        r = 8'h00;
        case (sc)
            7'h02: r = "1";
            7'h03: r = "2";
            7'h04: r = "3";
            7'h05: r = "4";
            7'h06: r = "5";
            7'h07: r = "6";
            7'h08: r = "7";
            7'h09: r = "8";
            7'h0a: r = "9";
            7'h0b: r = "0";
            7'h10: r = "q";
            7'h11: r = "w";
            7'h12: r = "e";
            7'h13: r = "r";
            7'h14: r = "t";
            7'h15: r = "y";
            7'h16: r = "u";
            7'h17: r = "i";
            7'h18: r = "o";
            7'h19: r = "p";
            7'h1e: r = "a";
            7'h1f: r = "s";
            7'h20: r = "d";
            7'h21: r = "f";
            7'h22: r = "g";
            7'h23: r = "h";
            7'h24: r = "j";
            7'h25: r = "k";
            7'h26: r = "l";
            7'h2c: r = "z";
            7'h2d: r = "x";
            7'h2e: r = "c";
            7'h2f: r = "v";
            7'h30: r = "b";
            7'h31: r = "n";
            7'h32: r = "m";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Shifted character of a printable key, zero when not printable
    function automatic logic [7:0] shifted_of(input logic [7:0] code);
        logic [7:0] r;
        r = 8'h00;
        case (code)
            "0": r = ")";
            "1": r = "!";
            "2": r = "@";
            "3": r = "#";
            "4": r = "$";
            "5": r = "%";
            "6": r = "^";
            "7": r = "&";
            "8": r = "*";
            "9": r = "(";
            default:
            begin
                if (code >= "a" && code <= "z")
                begin
                    r = code - 8'd32;
                end
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/ps2s1_ifs.sv]
`default_nettype none

// Raw scan byte channel
interface ps2s1_byte_if
    import ps2s1_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

// Key event channel
interface ps2s1_event_if
    import ps2s1_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] key_value;
    logic       was_down;
    logic       last_of_run;

    modport source (output valid, output event_kind, output key_value,
                    output was_down, output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input key_value,
                    input was_down, input last_of_run, output ready);
endinterface

`default_nettype wire

[sv/ps2s1_decode.sv]
`default_nettype none

module ps2s1_decode
    import ps2s1_pkg::*;
(
    input  wire logic [7:0] scan_byte,
    input  wire logic       prefix_pending,
    input  wire logic [7:0] left_shift_code,
    input  wire logic [7:0] right_shift_code,
    input  wire logic       prior,
    input  wire logic       left_held,
    input  wire logic       right_held,
    output dec_t            dec
);

    logic [6:0] sc;
    logic [7:0] rom_code;
    logic [7:0] code;
    logic       mapped;
    logic       is_make;
    logic [7:0] sh;
    logic       shift_held;

    // Map the 7-bit scan code to a key code
    always_comb
    begin
        sc       = scan_byte[6:0];
        rom_code = make_rom(sc);
        if (sc == LSHIFT_MAKE)
        begin
            code   = left_shift_code;
            mapped = 1'b1;
        end
        else if (sc == RSHIFT_MAKE)
        begin
            code   = right_shift_code;
            mapped = 1'b1;
        end
        else
        begin
            code   = rom_code;
            mapped = (rom_code != 8'h00);
        end
    end

    // Shift test sees the pressed key already down
    assign is_make    = ({1'b0, scan_byte} < 9'(MAKE_CODE_RANGE));
    assign sh         = shifted_of(code);
    assign shift_held = left_held  || (left_shift_code == code) ||
                        right_held || (right_shift_code == code);

    // Build results and the state update
    always_comb
    begin
        dec             = '0;
        dec.upd_code    = code;
        if (prefix_pending)
        begin
            dec.prefix_next = 1'b0;
        end
        else if (scan_byte == PREFIX_BYTE)
        begin
            dec.prefix_next = 1'b1;
        end
        else if (mapped && is_make)
        begin
            dec.upd_en             = 1'b1;
            dec.upd_val            = 1'b1;
            dec.ev0.event_kind     = KIND_DOWN;
            dec.ev0.key_value      = code;
            dec.ev0.was_down       = prior;
            if (sh == 8'h00)
            begin
                dec.count           = 2'd1;
                dec.ev0.last_of_run = 1'b1;
            end
            else
            begin
                dec.count           = 2'd2;
                dec.ev1.event_kind  = KIND_CHAR;
                dec.ev1.key_value   = shift_held ? sh : code;
                dec.ev1.last_of_run = 1'b1;
            end
        end
        else if (mapped)
        begin
            dec.upd_en          = 1'b1;
            dec.upd_val         = 1'b0;
            dec.count           = 2'd1;
            dec.ev0.event_kind  = KIND_UP;
            dec.ev0.key_value   = code;
            dec.ev0.last_of_run = 1'b1;
        end
    end

endmodule

`default_nettype wire

[sv/ps2_set1_scancode_to_key_events.sv]
`default_nettype none

// Channel   Role   Transaction
// scan      sink   one raw scan code set 1 byte
// events    source one key event (down, up or character)
// cfg_*     write  shift key code registers, index 0 left, 1 right
//
// A byte is taken into an input register together with the stored down bit of its key,
// decoded in one pass, and its results (up to two) land in a two-entry result register;
// the first result is then offered from the result register. The next byte is decoded as the last
// result leaves, so a printable key press, with two results, holds the next byte longer than
// any other byte. After reset the key store is cleared one entry a cycle (KEY_CODE_SPACE
// entries, 256 by default) with scan held off; a configuration write holds scan off while
// the shift key state is reloaded. Reset drops any byte or result in flight. Stalls on
// events back up into scan.

module ps2_set1_scancode_to_key_events
    import ps2s1_pkg::*;
#(
    parameter int unsigned KEY_CODE_SPACE = KEY_CODE_SPACE_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    ps2s1_byte_if.sink                  scan,
    ps2s1_event_if.source               events,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned KEY_W = $clog2(KEY_CODE_SPACE);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             prior_reg;
    logic             prefix_reg;
    logic [7:0]       left_shift_reg;
    logic [7:0]       right_shift_reg;
    logic             left_held_reg;
    logic             right_held_reg;
    logic             clearing_reg;
    logic             refresh_reg;
    logic [KEY_W-1:0] clr_addr_reg;
    logic             key_mem [KEY_CODE_SPACE];
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    event_t           res0_reg;
    event_t           res1_reg;
    dec_t             dec;
    logic [7:0]       in_code;
    logic [KEY_W-1:0] rd_addr;
    logic             in_fire;
    logic             fwd_hit;
    logic             out_fire;
    logic             advance;

    // Decode the held byte
    ps2s1_decode u_decode (
        .scan_byte        (in_byte_reg),
        .prefix_pending   (prefix_reg),
        .left_shift_code  (left_shift_reg),
        .right_shift_code (right_shift_reg),
        .prior            (prior_reg),
        .left_held        (left_held_reg),
        .right_held       (right_held_reg),
        .dec              (dec)
    );

    // Handshake and flow control
    assign out_fire   = events.valid && events.ready;
    assign advance    = in_valid_reg && ((cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_fire));
    assign scan.ready = !clearing_reg && !refresh_reg && (!in_valid_reg || advance);
    assign in_fire    = scan.valid && scan.ready;

    assign events.valid       = (cnt_reg != 2'd0);
    assign events.event_kind  = res0_reg.event_kind;
    assign events.key_value   = res0_reg.key_value;
    assign events.was_down    = res0_reg.was_down;
    assign events.last_of_run = res0_reg.last_of_run;

    always_comb
    begin
        if (advance)
        begin
            cnt_next = dec.count;
        end
        else if (out_fire)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    // Key code of the incoming byte, used as the key store read address
    always_comb
    begin
        if (scan.scan_byte[6:0] == LSHIFT_MAKE)
        begin
            in_code = left_shift_reg;
        end
        else if (scan.scan_byte[6:0] == RSHIFT_MAKE)
        begin
            in_code = right_shift_reg;
        end
        else
        begin
            in_code = make_rom(scan.scan_byte[6:0]);
        end
    end

    assign rd_addr = refresh_reg ? KEY_W'(left_shift_reg) : KEY_W'(in_code);
    assign fwd_hit = advance && dec.upd_en && (dec.upd_code == in_code);

    // Hold the incoming byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (scan.ready)
        begin
            in_valid_reg <= scan.valid;
        end
    end

    // Capture the byte and its key's down bit, bypassing a write in the same cycle
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= scan.scan_byte;
            prior_reg   <= fwd_hit ? dec.upd_val : key_mem[rd_addr];
        end
    end

    // Advance decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (advance)
            begin
                prefix_reg <= dec.prefix_next;
            end
        end
    end

    // Key store writes: clearing pass after reset, then at most one update per byte
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            key_mem[clr_addr_reg] <= 1'b0;
        end
        else if (advance && dec.upd_en)
        begin
            key_mem[KEY_W'(dec.upd_code)] <= dec.upd_val;
        end
    end

    // Clear sequencing and the down state of both shift key codes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            refresh_reg    <= 1'b0;
            left_held_reg  <= 1'b0;
            right_held_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + KEY_W'(1);
                if (clr_addr_reg == KEY_W'(KEY_CODE_SPACE - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (cfg_we)
            begin
                refresh_reg <= 1'b1;
            end
            else if (!clearing_reg)
            begin
                refresh_reg <= 1'b0;
            end
            if (refresh_reg && !clearing_reg)
            begin
                left_held_reg  <= key_mem[rd_addr];
                right_held_reg <= key_mem[KEY_W'(right_shift_reg)];
            end
            else if (advance && dec.upd_en)
            begin
                if (dec.upd_code == left_shift_reg)
                begin
                    left_held_reg <= dec.upd_val;
                end
                if (dec.upd_code == right_shift_reg)
                begin
                    right_held_reg <= dec.upd_val;
                end
            end
        end
    end

    // Load results, shift the second up on a pop
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res0_reg <= dec.ev0;
            res1_reg <= dec.ev1;
        end
        else if (out_fire)
        begin
            res0_reg <= res1_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_shift_reg  <= LEFT_SHIFT_RESET;
            right_shift_reg <= RIGHT_SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEFT_SHIFT:  left_shift_reg  <= cfg_data;
                CFG_RIGHT_SHIFT: right_shift_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

endmodule

`default_nettype wire
